### rtl/lpht_pkg.sv
`default_nettype none
package lpht_pkg;

    localparam int MAX_SLOTS_DEF = 256;

    // Status codes
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_GROWN    = 3'd1;
    localparam logic [2:0] ST_BLOCKED  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_FOUND    = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // Register indexes
    localparam int REG_START_SIZE = 0;
    localparam int REG_LOAD_LIMIT = 1;

    localparam logic [8:0] START_SIZE_RST = 9'd7;
    localparam logic [8:0] LOAD_LIMIT_RST = 9'd192;

    // Command to the shared remainder unit
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [16:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic        done;
        logic [16:0] rem;
    } t_mod_rsp;

endpackage
`default_nettype wire

### rtl/lpht_ram.sv
`default_nettype none
module lpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/lpht_mod.sv
`default_nettype none
// Restoring remainder, one quotient bit per cycle.
module lpht_mod (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lpht_pkg::t_mod_req i_req,
    output lpht_pkg::t_mod_rsp     o_rsp
);
    logic [31:0] r_num;
    logic [17:0] r_rem;
    logic [16:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [17:0] w_sh;
    logic [17:0] w_sub;

    assign w_sh  = {r_rem[16:0], r_num[31]};
    assign w_sub = w_sh - {1'b0, r_div};

    // Shift in one dividend bit, subtract when it fits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_num  <= i_req.dividend;
                r_div  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[30:0], 1'b0};
                r_rem <= w_sub[17] ? w_sh : w_sub;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem[16:0];
endmodule
`default_nettype wire

### rtl/linear_probe_hash_table.sv
// An item is hashed by the remainder unit, then slots are probed (read, wait, check) from the home
// slot until one settles it; a rejected insert (table full) goes straight to the result strobe.
// One item at a time; busy stays high until the strobe, and the next item can be accepted with it.
// Growth runs a trial division per candidate divisor, clears the new bank, reads each old slot
// and rehashes and probes each moved record. Results are strobed; receiver can't stall.
// Reset (sync, active low) and a start_size write clear bank 0 (all MAX_SLOTS slots), busy high.
`default_nettype none
module linear_probe_hash_table #(
    parameter int MAX_SLOTS = lpht_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         i_req_type,
    input  wire logic [31:0]                  i_key,
    input  wire logic [31:0]                  i_payload,
    output logic                              o_valid,
    output logic [2:0]                        o_status,
    output logic [31:0]                       o_found_payload,
    output logic [7:0]                        o_slot_index,
    output logic [8:0]                        o_table_size,
    output logic [8:0]                        o_entry_total,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    localparam int AW  = $clog2(MAX_SLOTS);
    localparam int SW  = AW + 1;
    localparam int MW  = AW + 1;
    localparam logic [SW-1:0] MAXS = SW'(MAX_SLOTS);

    typedef enum logic [15:0] {
        S_IDLE    = 16'b0000000000000001,
        S_HMOD    = 16'b0000000000000010,
        S_PRD     = 16'b0000000000000100,
        S_PWAIT   = 16'b0000000000001000,
        S_PCHK    = 16'b0000000000010000,
        S_PCAND   = 16'b0000000000100000,
        S_PTEST   = 16'b0000000001000000,
        S_CLR     = 16'b0000000010000000,
        S_RRD     = 16'b0000000100000000,
        S_RWAIT   = 16'b0000001000000000,
        S_RMOD    = 16'b0000010000000000,
        S_RPRB    = 16'b0000100000000000,
        S_ROLD    = 16'b0001000000000000,
        S_DONE    = 16'b0010000000000000,
        S_INIT    = 16'b0100000000000000,
        S_RCHK    = 16'b1000000000000000
    } t_state;

    t_state r_state;
    logic [8:0] r_start_size, r_load_limit;
    logic       r_bank;
    logic [SW-1:0] r_size, r_ns;
    logic [SW-1:0] r_count;
    logic       r_req;
    logic [31:0] r_key, r_pay;
    logic [AW-1:0] r_h, r_n;     // probe slot, probe counter
    logic [SW-1:0] r_i;          // rehash / clear index
    logic [AW-1:0] r_moved;
    logic [SW-1:0] r_d;          // prime trial divisor
    logic [2:0] r_status;
    logic [31:0] r_found;
    logic [AW-1:0] r_slot;
    logic [31:0] r_okey, r_odat;

    // Shared remainder unit
    lpht_pkg::t_mod_req w_mreq;
    lpht_pkg::t_mod_rsp w_mrsp;
    lpht_mod u_mod (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_mreq), .o_rsp(w_mrsp));

    // Memories: key, data and used flag, two banks each
    logic          w_we;
    logic [MW-1:0] w_wa, w_ra;
    logic [31:0]   w_wk, w_wd, w_rk, w_rd;
    logic          w_uwe, w_uwd, w_ur;
    logic [MW-1:0] w_uwa;
    lpht_ram #(.WIDTH(32), .DEPTH(2*MAX_SLOTS)) u_key (.i_clk(i_clk), .i_we(w_we),
        .i_waddr(w_wa), .i_wdata(w_wk), .i_raddr(w_ra), .o_rdata(w_rk));
    lpht_ram #(.WIDTH(32), .DEPTH(2*MAX_SLOTS)) u_dat (.i_clk(i_clk), .i_we(w_we),
        .i_waddr(w_wa), .i_wdata(w_wd), .i_raddr(w_ra), .o_rdata(w_rd));
    lpht_ram #(.WIDTH(1), .DEPTH(2*MAX_SLOTS)) u_used (.i_clk(i_clk), .i_we(w_uwe),
        .i_waddr(w_uwa), .i_wdata(w_uwd), .i_raddr(w_ra), .o_rdata(w_ur));

    logic w_cfg_wr;
    logic w_sel_size;
    assign w_cfg_wr   = psel && penable && pwrite;
    assign w_sel_size = (paddr[2] == 1'(lpht_pkg::REG_START_SIZE));
    assign pready     = 1'b1;
    assign busy       = (r_state != S_IDLE);

    // Read back registers
    always_comb begin
        if (w_sel_size) prdata = {23'd0, r_start_size};
        else            prdata = {23'd0, r_load_limit};
    end

    logic [8:0] w_clamp;
    always_comb begin
        if (pwdata[8:0] == 9'd0) w_clamp = 9'd1;
        else if ({23'd0, pwdata[8:0]} > 32'(MAX_SLOTS)) w_clamp = 9'(MAX_SLOTS);
        else w_clamp = pwdata[8:0];
    end

    // Probe helpers
    logic [AW-1:0] w_hnext_c, w_hnext_n;
    assign w_hnext_c  = ({1'b0, r_h} + 1'b1 == r_size) ? '0 : r_h + 1'b1;
    assign w_hnext_n  = ({1'b0, r_h} + 1'b1 == r_ns) ? '0 : r_h + 1'b1;
    logic [17:0] w_dsq;
    assign w_dsq = 18'(r_d) * 18'(r_d);

    always_comb begin
        w_mreq = '0;
        w_we   = 1'b0;
        w_wa   = {r_bank, r_h};
        w_wk   = r_key;
        w_wd   = r_pay;
        w_ra   = {r_bank, r_h};
        w_uwe  = 1'b0;
        w_uwa  = {r_bank, r_h};
        w_uwd  = 1'b0;
        unique case (r_state)
            // Clear bank 0 one slot a cycle
            S_INIT: begin
                w_uwe = 1'b1;
                w_uwa = {1'b0, r_i[AW-1:0]};
            end
            // Store the item in the first free slot
            S_PCHK: if (r_req == lpht_pkg::REQ_INSERT && !w_ur) begin
                w_we  = 1'b1;
                w_uwe = 1'b1;
                w_uwd = 1'b1;
            end
            S_CLR: begin
                w_uwe = 1'b1;
                w_uwa = {~r_bank, r_i[AW-1:0]};
            end
            S_RRD:  w_ra = {r_bank, r_i[AW-1:0]};
            S_RPRB: w_ra = {~r_bank, r_h};
            // Move a record into the new bank
            S_RCHK: if (!w_ur) begin
                w_we  = 1'b1;
                w_wa  = {~r_bank, r_h};
                w_wk  = r_okey;
                w_wd  = r_odat;
                w_uwe = 1'b1;
                w_uwa = {~r_bank, r_h};
                w_uwd = 1'b1;
            end
            default: ;
        endcase
        if (r_state == S_IDLE && start) begin
            w_mreq.start    = 1'b1;
            w_mreq.dividend = i_key;
            w_mreq.divisor  = 17'(r_size);
        end else if (r_state == S_PCAND) begin
            w_mreq.start    = 1'b1;
            w_mreq.dividend = 32'(r_ns);
            w_mreq.divisor  = 17'(r_d);
        end else if (r_state == S_RWAIT && w_ur) begin
            w_mreq.start    = 1'b1;
            w_mreq.dividend = w_rk;
            w_mreq.divisor  = 17'(r_ns);
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_i          <= '0;
            r_start_size <= lpht_pkg::START_SIZE_RST;
            r_load_limit <= lpht_pkg::LOAD_LIMIT_RST;
            r_bank       <= 1'b0;
            r_size       <= SW'(lpht_pkg::START_SIZE_RST);
            r_count      <= '0;
            o_valid      <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (w_cfg_wr && !w_sel_size) r_load_limit <= pwdata[8:0];
            if (w_cfg_wr && w_sel_size) begin
                r_start_size <= pwdata[8:0];
                r_size       <= SW'(w_clamp);
                r_bank       <= 1'b0;
                r_count      <= '0;
                r_i          <= '0;
                r_state      <= S_INIT;
            end else begin
                unique case (r_state)
                    S_INIT: begin
                        if (r_i == MAXS - 1'b1) begin
                            r_i     <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                    S_IDLE: if (start) begin
                        r_req   <= i_req_type;
                        r_key   <= i_key;
                        r_pay   <= i_payload;
                        r_found <= '0;
                        r_slot  <= '0;
                        r_n     <= '0;
                        if (i_req_type == lpht_pkg::REQ_INSERT && r_count >= r_size) begin
                            r_status <= lpht_pkg::ST_FULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_HMOD;
                        end
                    end
                    S_HMOD: if (w_mrsp.done) begin
                        r_h     <= w_mrsp.rem[AW-1:0];
                        r_state <= S_PRD;
                    end
                    S_PRD:   r_state <= S_PWAIT;
                    S_PWAIT: r_state <= S_PCHK;
                    S_PCHK: begin
                        if (r_req == lpht_pkg::REQ_INSERT) begin
                            if (!w_ur) begin
                                r_count  <= r_count + 1'b1;
                                r_slot   <= r_h;
                                r_moved  <= r_h;
                                r_status <= lpht_pkg::ST_INSERTED;
                                if (20'(r_count + 1'b1) * 20'd256 >
                                    20'(r_load_limit) * 20'(r_size)) begin
                                    r_ns    <= SW'({r_size, 1'b0});
                                    r_d     <= SW'(2);
                                    r_state <= S_PTEST;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end else begin
                                r_h     <= w_hnext_c;
                                r_state <= S_PRD;
                            end
                        end else begin
                            if (w_ur && w_rk == r_key) begin
                                r_status <= lpht_pkg::ST_FOUND;
                                r_found  <= w_rd;
                                r_slot   <= r_h;
                                r_state  <= S_DONE;
                            end else if ({1'b0, r_n} + 1'b1 == r_size) begin
                                r_status <= lpht_pkg::ST_NOTFOUND;
                                r_state  <= S_DONE;
                            end else begin
                                r_n     <= r_n + 1'b1;
                                r_h     <= w_hnext_c;
                                r_state <= S_PRD;
                            end
                        end
                    end
                    // Prime search: trial divisors while d*d <= ns
                    S_PTEST: begin
                        if ({r_size, 1'b0} > (SW+1)'(MAX_SLOTS) || r_ns > MAXS
                            || r_ns == '0) begin
                            r_status <= lpht_pkg::ST_BLOCKED;
                            r_state  <= S_DONE;
                        end else if (w_dsq > 18'(r_ns)) begin
                            r_i     <= '0;
                            r_state <= S_CLR;
                        end else begin
                            r_state <= S_PCAND;
                        end
                    end
                    S_PCAND: r_state <= S_ROLD;
                    S_ROLD: if (w_mrsp.done) begin
                        if (w_mrsp.rem == '0) begin
                            r_ns <= r_ns + 1'b1;
                            r_d  <= SW'(2);
                        end else begin
                            r_d <= r_d + 1'b1;
                        end
                        r_state <= S_PTEST;
                    end
                    // Clear the target bank, one slot a cycle
                    S_CLR: begin
                        if (r_i == MAXS - 1'b1) begin
                            r_i     <= '0;
                            r_state <= S_RRD;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                    // Walk the old bank in slot order
                    S_RRD: begin
                        if (r_i == r_size) begin
                            r_bank   <= ~r_bank;
                            r_size   <= r_ns;
                            r_slot   <= r_moved;
                            r_status <= lpht_pkg::ST_GROWN;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_RWAIT;
                        end
                    end
                    S_RWAIT: begin
                        if (w_ur) begin
                            r_okey  <= w_rk;
                            r_odat  <= w_rd;
                            r_state <= S_RMOD;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_RRD;
                        end
                    end
                    S_RMOD: if (w_mrsp.done) begin
                        r_h     <= w_mrsp.rem[AW-1:0];
                        r_state <= S_RPRB;
                    end
                    S_RPRB: r_state <= S_RCHK;
                    S_RCHK: begin
                        if (!w_ur) begin
                            if (r_i[AW-1:0] == r_slot) r_moved <= r_h;
                            r_i     <= r_i + 1'b1;
                            r_state <= S_RRD;
                        end else begin
                            r_h     <= w_hnext_n;
                            r_state <= S_RPRB;
                        end
                    end
                    S_DONE: begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    // Result ports
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            o_status        <= r_status;
            o_found_payload <= r_found;
            o_slot_index    <= 8'(r_slot);
            o_table_size    <= 9'(r_size);
            o_entry_total   <= 9'(r_count);
        end
    end

    // A result strobe follows only the done state
    a_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_DONE)) else $error("stray result");
    // Busy once an item is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("item not taken");
    // Count never exceeds size
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_size) else $error("count above size");
endmodule
`default_nettype wire
